[src/dmii_pkg.sv]
// Shared constants and types for the depth-mask integral image unit.
`default_nettype none

package dmii_pkg;

  // Frame size limits
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  // Field widths
  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned LIN_W   = $clog2(MAX_HEIGHT);
  localparam int unsigned ROW_W   = COL_W + 1;
  localparam int unsigned VAL_W   = 21;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned DELTA_W = 17;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned CFG_IDX_W = 2;

  // Register reset values
  localparam logic signed [DELTA_W-1:0] MIN_DELTA_RST = DELTA_W'(50);
  localparam logic signed [DELTA_W-1:0] MAX_DELTA_RST = DELTA_W'(100);
  localparam logic [SIZE_W-1:0]         WIDTH_RST     = SIZE_W'(640);
  localparam logic [SIZE_W-1:0]         HEIGHT_RST    = SIZE_W'(480);

  // Difference forced for a pixel without a reading
  localparam logic signed [DELTA_W:0] NO_READING_DELTA = -(DELTA_W+1)'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DELTA     = 2'd0,
    CFG_MAX_DELTA     = 2'd1,
    CFG_ACTIVE_WIDTH  = 2'd2,
    CFG_ACTIVE_HEIGHT = 2'd3
  } cfg_idx_t;

  // Classified pixel with its position and running row count
  typedef struct packed {
    logic             hit;
    logic [ROW_W-1:0] row_sum;
    logic [COL_W-1:0] col;
    logic [LIN_W-1:0] lin;
    logic             frame_end;
  } pix_t;

endpackage

`default_nettype wire

[src/dmii_if.sv]
// Valid/ready channel interfaces for depth pixels and integral results.
`default_nettype none

interface dmii_in_if;
  import dmii_pkg::*;
  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] depth_sample;
  logic [DEPTH_W-1:0] background_sample;
  logic               frame_start;

  modport source (output valid, depth_sample, background_sample, frame_start, input ready);
  modport sink   (input valid, depth_sample, background_sample, frame_start, output ready);
endinterface

interface dmii_out_if;
  import dmii_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [VAL_W-1:0] integral_value;
  logic [COL_W-1:0] column;
  logic [LIN_W-1:0] line;
  logic             frame_end;

  modport source (output valid, hit, integral_value, column, line, frame_end, input ready);
  modport sink   (input valid, hit, integral_value, column, line, frame_end, output ready);
endinterface

`default_nettype wire

[src/depth_mask_integral_image_unit.sv]
// Top level of the depth-mask integral image unit: config, line store and output stage.
//
// Usage:
// - in_pix carries one depth pixel and its background pixel per transfer, in
//   raster order; frame_start marks the first pixel of a frame. Without it the
//   position wraps to (0,0) after the last pixel of the configured frame.
// - out_pix carries one result per input pixel: hit flag, summed-area value,
//   column, line and frame_end, in input order.
// - cfg_we/cfg_index/cfg_wdata write min_delta, max_delta, active_width and
//   active_height; write only while no pixel is in flight.
// - Order: an accepted pixel is registered in stage 1, then moves to the output
//   register when stage 1 advances and transfers on out_pix from there.
//   Throughput: one pixel per cycle while out_pix does not stall, set by one
//   read and one write of the line store per pixel (read at accept, write as
//   it leaves stage 1). A write and a read of the same column in the same
//   cycle (width of one) is forwarded from the write data.
// - Reset (rst_n low, synchronous) clears the pipeline, counters and config
//   to its defaults. The line store is not cleared: line 0 uses zero in place of its read data.
// - When out_pix stalls, the output register holds and the stage behind it
//   holds; in_pix.ready drops only while both are full.
`default_nettype none

module depth_mask_integral_image_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  dmii_in_if.sink                              in_pix,
  dmii_out_if.source                           out_pix,
  input  wire logic                            cfg_we,
  input  wire logic [dmii_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dmii_pkg::CFG_W-1:0]      cfg_wdata
);

  import dmii_pkg::*;

  // Configuration registers
  logic signed [DELTA_W-1:0] min_delta_r;
  logic signed [DELTA_W-1:0] max_delta_r;
  logic [SIZE_W-1:0]         width_r;
  logic [SIZE_W-1:0]         height_r;
  logic [COL_W-1:0]          width_last;
  logic [LIN_W-1:0]          height_last;

  // Stage 1: line store read in flight
  logic             s1_valid_r;
  logic             s1_hit_r;
  logic [ROW_W-1:0] s1_row_sum_r;
  logic [COL_W-1:0] s1_col_r;
  logic [LIN_W-1:0] s1_lin_r;
  logic             s1_frame_end_r;
  logic             s1_fwd_r;
  logic [VAL_W-1:0] s1_fwd_val_r;

  // Output register
  logic             out_valid_r;
  logic             out_hit_r;
  logic [VAL_W-1:0] out_value_r;
  logic [COL_W-1:0] out_col_r;
  logic [LIN_W-1:0] out_lin_r;
  logic             out_frame_end_r;

  logic             in_acc;
  logic             s1_adv;
  logic [VAL_W-1:0] rd_data;
  logic [VAL_W-1:0] above;
  logic [VAL_W-1:0] s1_value;
  pix_t             cur;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_delta_r <= MIN_DELTA_RST;
      max_delta_r <= MAX_DELTA_RST;
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIN_DELTA:     min_delta_r <= cfg_wdata;
        CFG_MAX_DELTA:     max_delta_r <= cfg_wdata;
        CFG_ACTIVE_WIDTH:  width_r     <= cfg_wdata[SIZE_W-1:0];
        CFG_ACTIVE_HEIGHT: height_r    <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes: zero acts as one, anything above the limit as the limit
  always_comb begin
    if (width_r == '0) begin
      width_last = '0;
    end else if (32'(width_r) > MAX_WIDTH) begin
      width_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      width_last = COL_W'(32'(width_r) - 32'd1);
    end
    if (height_r == '0) begin
      height_last = '0;
    end else if (32'(height_r) > MAX_HEIGHT) begin
      height_last = LIN_W'(MAX_HEIGHT - 1);
    end else begin
      height_last = LIN_W'(32'(height_r) - 32'd1);
    end
  end

  // Handshake: stage 1 moves whenever the output register is free or draining
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_pix.ready);
  assign in_pix.ready = !s1_valid_r || s1_adv;
  assign in_acc       = in_pix.valid && in_pix.ready;

  dmii_pos u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (in_acc),
    .depth       (in_pix.depth_sample),
    .background  (in_pix.background_sample),
    .frame_start (in_pix.frame_start),
    .min_delta   (min_delta_r),
    .max_delta   (max_delta_r),
    .width_last  (width_last),
    .height_last (height_last),
    .cur         (cur)
  );

  // Line store: read at accept, write back when stage 1 advances
  dmii_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (s1_value),
    .re    (in_acc),
    .raddr (cur.col),
    .rdata (rd_data)
  );

  // Line 0 sees zero above; forward a write that lands on the column being read
  assign above    = (s1_lin_r == '0) ? '0 : (s1_fwd_r ? s1_fwd_val_r : rd_data);
  assign s1_value = above + VAL_W'(s1_row_sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_pix.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: load on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_hit_r       <= cur.hit;
      s1_row_sum_r   <= cur.row_sum;
      s1_col_r       <= cur.col;
      s1_lin_r       <= cur.lin;
      s1_frame_end_r <= cur.frame_end;
      s1_fwd_r       <= s1_adv && (s1_col_r == cur.col);
      s1_fwd_val_r   <= s1_value;
    end
    if (s1_adv) begin
      out_hit_r       <= s1_hit_r;
      out_value_r     <= s1_value;
      out_col_r       <= s1_col_r;
      out_lin_r       <= s1_lin_r;
      out_frame_end_r <= s1_frame_end_r;
    end
  end

  assign out_pix.valid          = out_valid_r;
  assign out_pix.hit            = out_hit_r;
  assign out_pix.integral_value = out_value_r;
  assign out_pix.column         = out_col_r;
  assign out_pix.line           = out_lin_r;
  assign out_pix.frame_end      = out_frame_end_r;

`ifndef SYNTHESIS
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted pixel missing from stage 1");

  a_fwd_only_col0: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_fwd_r |-> s1_col_r == '0)
    else $error("forwarding on a column other than zero");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_col_r) && $stable(s1_row_sum_r))
    else $error("stalled stage 1 lost its pixel");

  a_frame_end_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_frame_end_r |=> out_pix.valid && out_pix.frame_end)
    else $error("frame end not carried to output");
`endif

endmodule

`default_nettype wire

[src/dmii_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dmii_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[src/dmii_pos.sv]
// Pixel classifier, raster position counters and running row hit count.
`default_nettype none

module dmii_pos (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          acc,
  input  wire logic [dmii_pkg::DEPTH_W-1:0]  depth,
  input  wire logic [dmii_pkg::DEPTH_W-1:0]  background,
  input  wire logic                          frame_start,
  input  wire logic signed [dmii_pkg::DELTA_W-1:0] min_delta,
  input  wire logic signed [dmii_pkg::DELTA_W-1:0] max_delta,
  input  wire logic [dmii_pkg::COL_W-1:0]    width_last,
  input  wire logic [dmii_pkg::LIN_W-1:0]    height_last,
  output dmii_pkg::pix_t                     cur
);

  import dmii_pkg::*;

  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [LIN_W-1:0] lin_cnt_r, lin_cnt_nxt;
  logic [ROW_W-1:0] row_sum_r, row_sum_nxt;

  logic signed [DELTA_W:0] delta;
  logic [COL_W-1:0]        col;
  logic [LIN_W-1:0]        lin;
  logic [ROW_W-1:0]        sum_base;
  logic                    hit;
  logic                    row_end;
  logic                    frame_end;

  // A frame start clears the position before the pixel is placed
  assign col      = frame_start ? '0 : col_cnt_r;
  assign lin      = frame_start ? '0 : lin_cnt_r;
  assign sum_base = frame_start ? '0 : row_sum_r;

  always_comb begin
    if (depth == '0 || background == '0) begin
      delta = NO_READING_DELTA;
    end else begin
      delta = $signed({2'b00, background}) - $signed({2'b00, depth});
    end
  end

  assign hit = (delta >= (DELTA_W+1)'(min_delta)) && (delta <= (DELTA_W+1)'(max_delta));

  assign row_end   = col >= width_last;
  assign frame_end = row_end && (lin >= height_last);

  always_comb begin
    cur.hit       = hit;
    cur.row_sum   = sum_base + ROW_W'(hit);
    cur.col       = col;
    cur.lin       = lin;
    cur.frame_end = frame_end;
  end

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    lin_cnt_nxt = lin_cnt_r;
    row_sum_nxt = row_sum_r;
    if (acc) begin
      if (row_end) begin
        col_cnt_nxt = '0;
        row_sum_nxt = '0;
        lin_cnt_nxt = frame_end ? '0 : lin + LIN_W'(1);
      end else begin
        col_cnt_nxt = col + COL_W'(1);
        row_sum_nxt = cur.row_sum;
        lin_cnt_nxt = lin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      lin_cnt_r <= '0;
      row_sum_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      lin_cnt_r <= lin_cnt_nxt;
      row_sum_r <= row_sum_nxt;
    end
  end

`ifndef SYNTHESIS
  a_frame_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    acc && frame_end |=> col_cnt_r == '0 && lin_cnt_r == '0)
    else $error("position did not wrap after frame end");

  a_row_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> cur.row_sum <= ({1'b0, col} + ROW_W'(1)))
    else $error("row hit count exceeds pixels seen in row");
`endif

endmodule

`default_nettype wire
